// ===== hdl/pegcd_pkg.sv =====
// Shared types, constants and GF(101^2) arithmetic for the polynomial
// extended gcd unit. Depends on nothing else.
`timescale 1ns / 1ps

package pegcd_pkg;

	localparam int DEF_MAX_DEGREE = 31;
	localparam int P = 101;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOTCOP  = 2'd1;
	localparam logic [1:0] ST_OVERLNG = 2'd2;

	typedef struct packed {
		logic [6:0] re;
		logic [6:0] im;
	} fe_t;

	localparam fe_t FE_ZERO = '{re: 7'd0, im: 7'd0};
	localparam fe_t FE_ONE  = '{re: 7'd1, im: 7'd0};

	typedef struct packed {
		logic       poly_sel;
		logic [6:0] coef_re;
		logic [6:0] coef_im;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       out_sel;
		logic [6:0] out_re;
		logic [6:0] out_im;
		logic       out_last;
		logic [1:0] status;
	} res_t;

	typedef logic [6:0] inv_tab_t [0:P-1];

	// Built once at elaboration: modular inverses, entry zero holds zero.
	function automatic inv_tab_t build_inv();
		inv_tab_t t;
		for (int a = 0; a < P; a++) begin
			t[a] = 7'd0;
			for (int b = 1; b < P; b++) begin
				if ((a * b) % P == 1) begin
					t[a] = 7'(b);
				end
			end
		end
		return t;
	endfunction

	localparam inv_tab_t INV_ROM = build_inv();

	// Reduce a 7-bit digit that may lie in 101..127.
	function automatic logic [6:0] red7(input logic [6:0] x);
		return (x >= 7'(P)) ? 7'(x - 7'(P)) : x;
	endfunction

	// Remainder modulo 101 of a value below 2^15, by reciprocal and one correction.
	function automatic logic [6:0] mod101(input logic [14:0] a);
		logic [24:0] t;
		logic [8:0]  q;
		logic [15:0] r;
		t = 25'(a) * 25'd648;
		q = t[24:16];
		r = 16'(a) - 16'(q) * 16'd101;
		if (r >= 16'(P)) begin
			r = r - 16'(P);
		end
		return r[6:0];
	endfunction

	function automatic fe_t fmul(input fe_t x, input fe_t y);
		logic [14:0] a;
		logic [14:0] b;
		fe_t o;
		a = 15'(x.re) * 15'(y.re) + ((15'(x.im) * 15'(y.im)) << 1);
		b = 15'(x.re) * 15'(y.im) + 15'(x.im) * 15'(y.re);
		o.re = mod101(a);
		o.im = mod101(b);
		return o;
	endfunction

	function automatic fe_t fsub(input fe_t x, input fe_t y);
		fe_t o;
		o.re = (x.re >= y.re) ? 7'(x.re - y.re) : 7'(x.re + 7'(P) - y.re);
		o.im = (x.im >= y.im) ? 7'(x.im - y.im) : 7'(x.im + 7'(P) - y.im);
		return o;
	endfunction

	function automatic fe_t conj(input fe_t x);
		fe_t o;
		o.re = x.re;
		o.im = (x.im != 7'd0) ? 7'(7'(P) - x.im) : 7'd0;
		return o;
	endfunction

endpackage

// ===== hdl/poly_extended_gcd_gf_p2_unit.sv =====
// Extended Euclid over GF(101^2)[x]: load, sequencer, working stores and one
// shared field multiplier. Depends on pegcd_pkg.
`timescale 1ns / 1ps

// The unit takes the coefficients of d, then of r, each lowest first, one word
// per cycle, and starts when the r word marked last arrives. It then stalls its
// input while it runs Euclid on a single GF(101^2) multiplier: every quotient
// term, remainder update, Bezout update and inverse uses that one unit, one
// product a cycle. Each division step clears the quotient and inverts the
// divisor's lead coefficient; per quotient term it forms the term from the
// numerator's lead coefficient, subtracts its product with every divisor
// coefficient and trims zeros. Each Bezout update clears, takes one product per
// term and trims zeros. The results (u, then v, lowest first, or one status
// word) leave at up to one word per cycle while res_stall is low, and the next
// load may start while the final word still waits in the output register.
module poly_extended_gcd_gf_p2_unit #(
	parameter int MAX_DEGREE = pegcd_pkg::DEF_MAX_DEGREE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  pegcd_pkg::item_t  item,
	output logic              res_valid,
	input  logic              res_stall,
	output pegcd_pkg::res_t   res
);

	localparam int CAP  = MAX_DEGREE + 1;
	localparam int CW   = $clog2(CAP + 1);
	localparam int QW   = $clog2(CAP);
	localparam int IW   = $clog2(CAP);
	localparam int LW   = $clog2(CAP + 1);

	typedef enum logic [4:0] {
		S_LOAD, S_START, S_INITV, S_TRIM0, S_TRIM1, S_CHECK, S_QCLR, S_INV0, S_INV1,
		S_DIVF, S_DIVS, S_DIVT, S_UCLR, S_UMAC, S_UTRIM, S_SWAP, S_FIN, S_FINV0,
		S_FINV1, S_EMIT, S_ONE
	} state_t;

	state_t           state_q;
	logic             p_q;
	logic [CW-1:0]    dcnt_q, rcnt_q;
	logic             ovf_q;
	logic [LW-1:0]    n0_q, n1_q, nq_q, i_q, j_q, k_q;
	logic [LW-1:0]    len0_q [2];
	logic [LW-1:0]    len1_q [2];
	logic             wsel_q;
	logic [6:0]       norm_q;
	pegcd_pkg::fe_t   li_q, f_q;
	logic [1:0]       stat_q;
	pegcd_pkg::res_t  res_q;
	logic             res_valid_q;

	// Remainder pair and Bezout pairs, one small register file per polynomial.
	pegcd_pkg::fe_t   rem0_q [CAP];
	pegcd_pkg::fe_t   rem1_q [CAP];
	pegcd_pkg::fe_t   ua_q   [CAP];
	pegcd_pkg::fe_t   ub_q   [CAP];
	pegcd_pkg::fe_t   va_q   [CAP];
	pegcd_pkg::fe_t   vb_q   [CAP];
	pegcd_pkg::fe_t   quot_q [CAP];

	logic             item_acc;
	logic             out_free;
	pegcd_pkg::fe_t   mul_a, mul_b, mul_p, cin;
	logic [LW-1:0]    sh, blen;
	logic [IW-1:0]    n0m1, n1m1, shj, ij, km1, jx, ix;
	pegcd_pkg::fe_t   num_top, den_top, num_shj, num_low, den_j;
	pegcd_pkg::fe_t   w_ij, w_top, w_old_j, w_emit;

	logic             rem_we, rem_ws;
	logic [IW-1:0]    rem_wi;
	pegcd_pkg::fe_t   rem_wd;
	logic             w_we, w_wsel, w_ws;
	logic [IW-1:0]    w_wi;
	pegcd_pkg::fe_t   w_wd;
	logic             q_we;
	logic [QW-1:0]    q_wi;
	pegcd_pkg::fe_t   q_wd;

	assign item_stall = (state_q != S_LOAD);
	assign item_acc   = item_valid && !item_stall;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign out_free   = !res_valid_q || !res_stall;

	assign cin.re = pegcd_pkg::red7(item.coef_re);
	assign cin.im = pegcd_pkg::red7(item.coef_im);

	assign sh   = n0_q - n1_q;
	assign n0m1 = IW'(n0_q - 1'b1);
	assign n1m1 = IW'(n1_q - 1'b1);
	assign shj  = IW'(sh + j_q);
	assign ij   = IW'(i_q + j_q);
	assign km1  = IW'(k_q - 1'b1);
	assign jx   = IW'(j_q);
	assign ix   = IW'(i_q);

	// The numerator sits in the file selected by p, the divisor in the other.
	assign num_top = p_q ? rem1_q[n0m1] : rem0_q[n0m1];
	assign den_top = p_q ? rem0_q[n1m1] : rem1_q[n1m1];
	assign num_shj = p_q ? rem1_q[shj]  : rem0_q[shj];
	assign num_low = p_q ? rem1_q[0]    : rem0_q[0];
	assign den_j   = p_q ? rem0_q[jx]   : rem1_q[jx];

	assign w_ij    = wsel_q ? (p_q ? vb_q[ij] : va_q[ij]) : (p_q ? ub_q[ij] : ua_q[ij]);
	assign w_top   = wsel_q ? (p_q ? vb_q[km1] : va_q[km1]) :
		(p_q ? ub_q[km1] : ua_q[km1]);
	assign w_old_j = wsel_q ? (p_q ? va_q[jx] : vb_q[jx]) : (p_q ? ua_q[jx] : ub_q[jx]);
	assign w_emit  = wsel_q ? (p_q ? vb_q[ix] : va_q[ix]) : (p_q ? ub_q[ix] : ua_q[ix]);

	// Length of q times the older Bezout polynomial.
	assign blen = (nq_q != '0 && len1_q[wsel_q] != '0) ?
		LW'(nq_q + len1_q[wsel_q] - 1'b1) : '0;

	always_comb begin
		mul_a = pegcd_pkg::FE_ZERO;
		mul_b = pegcd_pkg::FE_ZERO;
		unique case (state_q)
			S_INV0: begin
				mul_a = den_top;
				mul_b = pegcd_pkg::conj(den_top);
			end
			S_INV1: begin
				mul_a = pegcd_pkg::conj(den_top);
				mul_b = '{re: pegcd_pkg::INV_ROM[norm_q], im: 7'd0};
			end
			S_FINV0: begin
				mul_a = num_low;
				mul_b = pegcd_pkg::conj(num_low);
			end
			S_FINV1: begin
				mul_a = pegcd_pkg::conj(num_low);
				mul_b = '{re: pegcd_pkg::INV_ROM[norm_q], im: 7'd0};
			end
			S_DIVF: begin
				mul_a = num_top;
				mul_b = li_q;
			end
			S_DIVS: begin
				mul_a = f_q;
				mul_b = den_j;
			end
			S_UMAC: begin
				mul_a = quot_q[QW'(i_q)];
				mul_b = w_old_j;
			end
			S_EMIT: begin
				mul_a = li_q;
				mul_b = w_emit;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = pegcd_pkg::fmul(mul_a, mul_b);

	always_comb begin
		rem_we = 1'b0;
		rem_ws = p_q;
		rem_wi = '0;
		rem_wd = cin;
		w_we   = 1'b0;
		w_wsel = wsel_q;
		w_ws   = p_q;
		w_wi   = '0;
		w_wd   = pegcd_pkg::FE_ZERO;
		q_we   = 1'b0;
		q_wi   = '0;
		q_wd   = pegcd_pkg::FE_ZERO;
		unique case (state_q)
			S_LOAD: begin
				if (item_acc) begin
					if (!item.poly_sel) begin
						rem_we = (dcnt_q < CW'(CAP));
						rem_wi = IW'(dcnt_q);
					end else begin
						rem_we = (rcnt_q < CW'(CAP));
						rem_ws = ~p_q;
						rem_wi = IW'(rcnt_q);
					end
				end
			end
			S_START: begin
				w_we   = !ovf_q;
				w_wsel = 1'b0;
				w_wd   = pegcd_pkg::FE_ONE;
			end
			S_INITV: begin
				w_we   = 1'b1;
				w_wsel = 1'b1;
				w_ws   = ~p_q;
				w_wd   = pegcd_pkg::FE_ONE;
			end
			S_QCLR: begin
				q_we = 1'b1;
				q_wi = QW'(i_q);
			end
			S_DIVF: begin
				q_we = (n0_q >= n1_q);
				q_wi = QW'(sh);
				q_wd = mul_p;
			end
			S_DIVS: begin
				rem_we = 1'b1;
				rem_wi = shj;
				rem_wd = pegcd_pkg::fsub(num_shj, mul_p);
			end
			S_UCLR: begin
				w_we = (k_q < blen);
				w_wi = IW'(k_q);
			end
			S_UMAC: begin
				w_we = 1'b1;
				w_wi = ij;
				w_wd = pegcd_pkg::fsub(w_ij, mul_p);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			if (rem_ws) begin
				rem1_q[rem_wi] <= rem_wd;
			end else begin
				rem0_q[rem_wi] <= rem_wd;
			end
		end
		if (w_we) begin
			unique case ({w_wsel, w_ws})
				2'b00: ua_q[w_wi] <= w_wd;
				2'b01: ub_q[w_wi] <= w_wd;
				2'b10: va_q[w_wi] <= w_wd;
				2'b11: vb_q[w_wi] <= w_wd;
			endcase
		end
		if (q_we) begin
			quot_q[q_wi] <= q_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			p_q         <= 1'b0;
			dcnt_q      <= '0;
			rcnt_q      <= '0;
			ovf_q       <= 1'b0;
			n0_q        <= '0;
			n1_q        <= '0;
			nq_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			len0_q[0]   <= '0;
			len0_q[1]   <= '0;
			len1_q[0]   <= '0;
			len1_q[1]   <= '0;
			wsel_q      <= 1'b0;
			norm_q      <= '0;
			li_q        <= pegcd_pkg::FE_ZERO;
			f_q         <= pegcd_pkg::FE_ZERO;
			stat_q      <= pegcd_pkg::ST_OK;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (item_acc) begin
						if (!item.poly_sel) begin
							if (dcnt_q < CW'(CAP)) begin
								dcnt_q <= dcnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							if (rcnt_q < CW'(CAP)) begin
								rcnt_q <= rcnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
							if (item.last) begin
								state_q <= S_START;
							end
						end
					end
				end
				S_START: begin
					if (ovf_q) begin
						stat_q  <= pegcd_pkg::ST_OVERLNG;
						state_q <= S_ONE;
					end else begin
						n0_q      <= LW'(dcnt_q);
						n1_q      <= LW'(rcnt_q);
						len0_q[0] <= LW'(1);
						len1_q[0] <= '0;
						len0_q[1] <= '0;
						len1_q[1] <= LW'(1);
						state_q   <= S_INITV;
					end
				end
				S_INITV: begin
					state_q <= S_TRIM0;
				end
				S_TRIM0: begin
					if (n0_q != '0 && num_top == pegcd_pkg::FE_ZERO) begin
						n0_q <= n0_q - 1'b1;
					end else begin
						state_q <= S_TRIM1;
					end
				end
				S_TRIM1: begin
					if (n1_q != '0 && den_top == pegcd_pkg::FE_ZERO) begin
						n1_q <= n1_q - 1'b1;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (n1_q == '0) begin
						state_q <= S_FIN;
					end else if (n0_q < n1_q) begin
						nq_q    <= '0;
						wsel_q  <= 1'b0;
						k_q     <= len0_q[0];
						state_q <= S_UCLR;
					end else begin
						nq_q    <= LW'(sh + 1'b1);
						i_q     <= '0;
						state_q <= S_QCLR;
					end
				end
				S_QCLR: begin
					if (i_q == LW'(nq_q - 1'b1)) begin
						state_q <= S_INV0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_INV0: begin
					norm_q  <= mul_p.re;
					state_q <= S_INV1;
				end
				S_INV1: begin
					li_q    <= mul_p;
					state_q <= S_DIVF;
				end
				S_DIVF: begin
					if (n0_q >= n1_q) begin
						f_q     <= mul_p;
						j_q     <= '0;
						state_q <= S_DIVS;
					end else begin
						wsel_q  <= 1'b0;
						k_q     <= len0_q[0];
						state_q <= S_UCLR;
					end
				end
				S_DIVS: begin
					if (j_q == LW'(n1_q - 1'b1)) begin
						state_q <= S_DIVT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DIVT: begin
					if (n0_q != '0 && num_top == pegcd_pkg::FE_ZERO) begin
						n0_q <= n0_q - 1'b1;
					end else begin
						state_q <= S_DIVF;
					end
				end
				S_UCLR: begin
					// Zero the newer Bezout polynomial up to the product length; k then
					// holds the longer of the two lengths.
					if (k_q < blen) begin
						k_q <= k_q + 1'b1;
					end else if (blen != '0) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_UMAC;
					end else begin
						state_q <= S_UTRIM;
					end
				end
				S_UMAC: begin
					if (j_q == LW'(len1_q[wsel_q] - 1'b1)) begin
						j_q <= '0;
						if (i_q == LW'(nq_q - 1'b1)) begin
							state_q <= S_UTRIM;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_UTRIM: begin
					if (k_q != '0 && w_top == pegcd_pkg::FE_ZERO) begin
						k_q <= k_q - 1'b1;
					end else begin
						len0_q[wsel_q] <= len1_q[wsel_q];
						len1_q[wsel_q] <= k_q;
						if (!wsel_q) begin
							wsel_q  <= 1'b1;
							k_q     <= len0_q[1];
							state_q <= S_UCLR;
						end else begin
							state_q <= S_SWAP;
						end
					end
				end
				S_SWAP: begin
					p_q     <= ~p_q;
					n0_q    <= n1_q;
					n1_q    <= n0_q;
					state_q <= S_CHECK;
				end
				S_FIN: begin
					if (n0_q != LW'(1)) begin
						stat_q  <= pegcd_pkg::ST_NOTCOP;
						state_q <= S_ONE;
					end else begin
						state_q <= S_FINV0;
					end
				end
				S_FINV0: begin
					norm_q  <= mul_p.re;
					state_q <= S_FINV1;
				end
				S_FINV1: begin
					li_q    <= mul_p;
					wsel_q  <= 1'b0;
					i_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (i_q == len0_q[wsel_q]) begin
						if (!wsel_q) begin
							wsel_q <= 1'b1;
							i_q    <= '0;
						end else begin
							dcnt_q  <= '0;
							rcnt_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end
					end else if (out_free) begin
						res_q.out_sel  <= wsel_q;
						res_q.out_re   <= mul_p.re;
						res_q.out_im   <= mul_p.im;
						res_q.out_last <= (i_q == LW'(len0_q[wsel_q] - 1'b1)) &&
							(wsel_q || len0_q[1] == '0);
						res_q.status   <= pegcd_pkg::ST_OK;
						res_valid_q    <= 1'b1;
						i_q            <= i_q + 1'b1;
					end
				end
				S_ONE: begin
					if (out_free) begin
						res_q.out_sel  <= 1'b0;
						res_q.out_re   <= 7'd0;
						res_q.out_im   <= 7'd0;
						res_q.out_last <= 1'b1;
						res_q.status   <= stat_q;
						res_valid_q    <= 1'b1;
						dcnt_q         <= '0;
						rcnt_q         <= '0;
						ovf_q          <= 1'b0;
						state_q        <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule
